/* rtl/ffba_pkg.sv */
`timescale 1ns / 1ps

package ffba_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_ALLOCATED    = 3'd0;
    localparam status_t ST_BAD_SIZE     = 3'd1;
    localparam status_t ST_NO_SPACE     = 3'd2;
    localparam status_t ST_FREED        = 3'd3;
    localparam status_t ST_FREE_IGNORED = 3'd4;

    localparam int unsigned BYTES_W = 17;
    localparam int unsigned ACC_W   = 18;

endpackage

/* rtl/first_fit_block_allocator.sv */
`timescale 1ns / 1ps

// First-fit allocator over BLOCK_COUNT blocks of BLOCK_BYTES bytes, one transaction at a time.
// After reset the block runs a clearing pass over every entry of its state memory and
// stalls input until it ends. An allocate is dispatched from idle with block 0 on the read
// port, then walks the blocks from the lowest index at one block per cycle until the first
// fitting free run is found or the last block is reached, then writes one block of the run
// per cycle; a zero or oversized request is answered without a walk. A free walks block
// offsets at one per cycle until the offset matches, reads the entry, then clears one
// block of the run per cycle. The state memory holds a used flag and a run length per
// block and is never read and written in the same cycle. A finished result sits in an
// output register, so the next transaction is taken while it waits to be delivered.
module first_fit_block_allocator #(
    parameter int BLOCK_COUNT = 128,
    parameter int BLOCK_BYTES = 800
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [16:0]       request_bytes,
    input  logic [16:0]       free_offset,
    output logic              out_valid,
    input  logic              out_stall,
    output ffba_pkg::status_t status,
    output logic [16:0]       offset
);

    import ffba_pkg::*;

    localparam int IW = $clog2(BLOCK_COUNT);
    localparam int LW = $clog2(BLOCK_COUNT + 1);
    localparam int MW = LW + 1;
    localparam logic [IW-1:0] LAST = IW'(BLOCK_COUNT - 1);
    localparam logic [31:0] POOL = 32'(BLOCK_COUNT * BLOCK_BYTES);
    localparam logic [ACC_W-1:0] BB_ACC = ACC_W'(BLOCK_BYTES);
    localparam logic [BYTES_W-1:0] BB_OFF = BYTES_W'(BLOCK_BYTES);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ASCAN  = 3'd2;
    localparam logic [2:0] S_AWRITE = 3'd3;
    localparam logic [2:0] S_FSCAN  = 3'd4;
    localparam logic [2:0] S_FCHK   = 3'd5;
    localparam logic [2:0] S_FCLR   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      wr_idx_reg, wr_idx_next;
    logic [IW-1:0]      start_reg, start_next;
    logic [IW-1:0]      end_reg, end_next;
    logic [LW-1:0]      cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [BYTES_W-1:0] cur_off_reg, cur_off_next;
    logic [BYTES_W-1:0] start_off_reg, start_off_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [BYTES_W-1:0] off_reg, off_next;
    status_t            res_status_reg, res_status_next;
    logic [BYTES_W-1:0] res_offset_reg, res_offset_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [BYTES_W-1:0] offset_reg, offset_next;

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [MW-1:0]      wr_data;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [MW-1:0]      rd_data;

    logic               ent_used;
    logic [LW-1:0]      ent_len;
    logic [IW-1:0]      run_start;
    logic [BYTES_W-1:0] run_off;
    logic [LW-1:0]      cnt_inc;
    logic [ACC_W-1:0]   acc_inc;
    logic               in_fire;

    assign ent_used  = rd_data[LW];
    assign ent_len   = rd_data[LW-1:0];
    assign run_start = (cnt_reg == '0) ? idx_reg : start_reg;
    assign run_off   = (cnt_reg == '0) ? cur_off_reg : start_off_reg;
    assign cnt_inc   = cnt_reg + LW'(1);
    assign acc_inc   = acc_reg + BB_ACC;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;

    ffba_ram #(
        .DEPTH(BLOCK_COUNT),
        .WIDTH(MW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        wr_idx_next     = wr_idx_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        cur_off_next    = cur_off_reg;
        start_off_next  = start_off_reg;
        bytes_next      = bytes_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        status_next     = status_reg;
        offset_next     = offset_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        wr_addr         = wr_idx_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (wr_idx_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_idx_next = wr_idx_reg + IW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    bytes_next   = request_bytes;
                    off_next     = free_offset;
                    idx_next     = '0;
                    cnt_next     = '0;
                    acc_next     = '0;
                    cur_off_next = '0;
                    if (command)
                    begin
                        state_next = S_FSCAN;
                    end
                    else if (request_bytes == '0 || {15'd0, request_bytes} > POOL)
                    begin
                        res_status_next = ST_BAD_SIZE;
                        res_offset_next = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // block 0 is on the read port when the walk starts
                        rd_en      = 1'b1;
                        state_next = S_ASCAN;
                    end
                end
            end
            S_ASCAN:
            begin
                if (!ent_used && acc_inc >= {1'b0, bytes_reg})
                begin
                    start_next     = run_start;
                    start_off_next = run_off;
                    end_next       = idx_reg;
                    wr_idx_next    = run_start;
                    cnt_next       = cnt_inc;
                    state_next     = S_AWRITE;
                end
                else if (idx_reg == LAST)
                begin
                    res_status_next = ST_NO_SPACE;
                    res_offset_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (ent_used)
                    begin
                        cnt_next = '0;
                        acc_next = '0;
                    end
                    else
                    begin
                        start_next     = run_start;
                        start_off_next = run_off;
                        cnt_next       = cnt_inc;
                        acc_next       = acc_inc;
                    end
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg + IW'(1);
                    idx_next     = idx_reg + IW'(1);
                    cur_off_next = cur_off_reg + BB_OFF;
                end
            end
            S_AWRITE:
            begin
                wr_en   = 1'b1;
                wr_data = {1'b1, (wr_idx_reg == start_reg) ? cnt_reg : LW'(0)};
                if (wr_idx_reg == end_reg)
                begin
                    res_status_next = ST_ALLOCATED;
                    res_offset_next = start_off_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    wr_idx_next = wr_idx_reg + IW'(1);
                end
            end
            S_FSCAN:
            begin
                // acc holds the byte offset of block idx, never wrapped
                if (acc_reg == {1'b0, off_reg})
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg;
                    state_next = S_FCHK;
                end
                else if (acc_reg > {1'b0, off_reg} || idx_reg == LAST)
                begin
                    res_status_next = ST_FREE_IGNORED;
                    res_offset_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                    acc_next = acc_inc;
                end
            end
            S_FCHK:
            begin
                if (!ent_used || ent_len == '0)
                begin
                    res_status_next = ST_FREE_IGNORED;
                    res_offset_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    cnt_next    = ent_len;
                    wr_idx_next = idx_reg;
                    state_next  = S_FCLR;
                end
            end
            S_FCLR:
            begin
                wr_en = 1'b1;
                if (cnt_reg == LW'(1) || wr_idx_reg == LAST)
                begin
                    res_status_next = ST_FREED;
                    res_offset_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    cnt_next    = cnt_reg - LW'(1);
                    wr_idx_next = wr_idx_reg + IW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    offset_next    = res_offset_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            wr_idx_reg    <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        end_reg        <= end_next;
        cur_off_reg    <= cur_off_next;
        start_off_reg  <= start_off_next;
        bytes_reg      <= bytes_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        status_reg     <= status_next;
        offset_reg     <= offset_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign offset    = offset_reg;

`ifndef SYNTHESIS
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("state memory read and written in the same cycle");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("state memory written outside a transaction");

    a_run_start_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ASCAN && cnt_reg != '0) |-> (start_reg <= idx_reg))
        else $error("free run start beyond scan position");

    a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FCLR || state_reg == S_AWRITE) |-> (cnt_reg != '0))
        else $error("run write with zero length");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_ALLOCATED) |-> (offset_reg == '0))
        else $error("nonzero offset on a failed or free result");
`endif

endmodule

/* rtl/ffba_ram.sv */
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* bench/first_fit_block_allocator_test.sv */
`timescale 1ns / 1ps

module first_fit_block_allocator_test;

    import ffba_pkg::*;

    localparam int BLOCK_COUNT  = 128;
    localparam int BLOCK_BYTES  = 800;
    localparam int POOL_BYTES   = BLOCK_COUNT * BLOCK_BYTES;
    localparam int SMALL_BYTES  = 6 * BLOCK_BYTES;

    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_FREE   = 1'b1;

    localparam int RANDOM_ITEMS = 1625;
    localparam int LONG_HOLD    = 400;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic        cmd;
        logic [16:0] nbytes;
        logic [16:0] foff;
        bit          typed;
        status_t     st;
        logic [16:0] ofs;
    } request_row_t;

    typedef struct packed {
        status_t     st;
        logic [16:0] ofs;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [16:0] request_bytes;
    logic [16:0] free_offset;
    logic        out_valid;
    logic        out_stall = 1'b0;
    status_t     status;
    logic [16:0] offset;

    first_fit_block_allocator #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .request_bytes (request_bytes),
        .free_offset   (free_offset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .offset        (offset)
    );

    // shadow copy of the pool
    bit           block_taken [BLOCK_COUNT];
    int           run_blocks  [BLOCK_COUNT];

    reply_t       awaited_replies [$];
    request_row_t directed_rows [$];

    int errors       = 0;
    int idle_cycles  = 0;
    int rx_wait      = 0;
    int hold_left    = 0;
    bit hold_off_req = 1'b0;
    bit tx_gaps_on   = 1'b1;
    bit rx_gaps_on   = 1'b1;

    always #10 clk = ~clk;

    function automatic void compute_reply(input logic cmd, input logic [16:0] nbytes,
                                          input logic [16:0] foff, output reply_t rep);
        int need;
        int run;
        int first;
        int idx;
        int k;
        bit found;
        rep.ofs = '0;
        if (cmd == CMD_ALLOC)
        begin
            if (nbytes == 0 || int'(nbytes) > POOL_BYTES)
            begin
                rep.st = ST_BAD_SIZE;
            end
            else
            begin
                need  = (int'(nbytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                run   = 0;
                first = 0;
                found = 1'b0;
                for (k = 0; k < BLOCK_COUNT && !found; k++)
                begin
                    if (block_taken[k])
                    begin
                        run = 0;
                    end
                    else
                    begin
                        if (run == 0)
                            first = k;
                        run++;
                        if (run == need)
                            found = 1'b1;
                    end
                end
                if (found)
                begin
                    for (k = first; k < first + need; k++)
                        block_taken[k] = 1'b1;
                    run_blocks[first] = need;
                    rep.st  = ST_ALLOCATED;
                    rep.ofs = 17'(first * BLOCK_BYTES);
                end
                else
                begin
                    rep.st = ST_NO_SPACE;
                end
            end
        end
        else
        begin
            rep.st = ST_FREE_IGNORED;
            idx = int'(foff) / BLOCK_BYTES;
            // only the first block of a live run releases anything
            if (int'(foff) % BLOCK_BYTES == 0 && idx < BLOCK_COUNT)
            begin
                if (block_taken[idx] && run_blocks[idx] != 0)
                begin
                    for (k = idx; k < idx + run_blocks[idx] && k < BLOCK_COUNT; k++)
                        block_taken[k] = 1'b0;
                    run_blocks[idx] = 0;
                    rep.st = ST_FREED;
                end
            end
        end
    endfunction

    function automatic void add_row(input logic cmd, input int nbytes, input int foff,
                                    input bit typed, input status_t st, input int ofs);
        request_row_t row;
        row.cmd    = cmd;
        row.nbytes = 17'(nbytes);
        row.foff   = 17'(foff);
        row.typed  = typed;
        row.st     = st;
        row.ofs    = 17'(ofs);
        directed_rows.push_back(row);
    endfunction

    task automatic make_random_row(output request_row_t row);
        int starts [$];
        int r;
        int k;
        r          = $urandom_range(0, 99);
        row.nbytes = 17'($urandom);
        row.foff   = 17'($urandom);
        row.typed  = 1'b0;
        row.st     = ST_ALLOCATED;
        row.ofs    = '0;
        for (k = 0; k < BLOCK_COUNT; k++)
            if (run_blocks[k] != 0)
                starts.push_back(k);
        if (r < 40 && starts.size() != 0)
        begin
            row.cmd  = CMD_FREE;
            row.foff = 17'(starts[$urandom_range(0, starts.size() - 1)] * BLOCK_BYTES);
        end
        else if (r < 45)
        begin
            row.cmd  = CMD_FREE;
            row.foff = 17'($urandom_range(0, BLOCK_COUNT + 2) * BLOCK_BYTES);
        end
        else if (r < 50)
        begin
            row.cmd = CMD_FREE;
        end
        else if (r < 55)
        begin
            row.cmd = CMD_ALLOC;
        end
        else
        begin
            row.cmd    = CMD_ALLOC;
            row.nbytes = 17'($urandom_range(1, SMALL_BYTES));
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input request_row_t row);
        int gap;
        reply_t rep;
        gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        command       = row.cmd;
        request_bytes = row.nbytes;
        free_offset   = row.foff;
        do
            @(posedge clk);
        while (in_stall);
        compute_reply(row.cmd, row.nbytes, row.foff, rep);
        if (row.typed)
        begin
            rep.st  = row.st;
            rep.ofs = row.ofs;
        end
        awaited_replies.push_back(rep);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (rx_wait > 0)
        begin
            out_stall = 1'b1;
            rx_wait--;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (hold_off_req && hold_left == 0)
        begin
            hold_left    = LONG_HOLD;
            hold_off_req = 1'b0;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d offset %0d",
                         $time, status, offset);
                errors++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.st, status);
                    errors++;
                end
                if (offset !== want.ofs)
                begin
                    $display("%0t: offset mismatch, expected %0d, got %0d",
                             $time, want.ofs, offset);
                    errors++;
                end
            end
            rx_wait = rx_gaps_on ? $urandom_range(0, 5) : 0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        request_row_t row;
        int n;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_ALLOC;
        request_bytes = '0;
        free_offset   = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        //      command    bytes   offset  typed  status           offset
        add_row(CMD_ALLOC, 0,      0,      1'b1, ST_BAD_SIZE,     0);
        add_row(CMD_ALLOC, 102401, 0,      1'b1, ST_BAD_SIZE,     0);
        add_row(CMD_ALLOC, 131071, 0,      1'b1, ST_BAD_SIZE,     0);
        add_row(CMD_ALLOC, 1,      0,      1'b1, ST_ALLOCATED,    0);
        add_row(CMD_ALLOC, 800,    0,      1'b0, ST_ALLOCATED,    0);
        add_row(CMD_ALLOC, 801,    0,      1'b0, ST_ALLOCATED,    0);
        add_row(CMD_FREE,  0,      0,      1'b1, ST_FREED,        0);
        add_row(CMD_FREE,  0,      0,      1'b1, ST_FREE_IGNORED, 0);
        add_row(CMD_FREE,  0,      2400,   1'b1, ST_FREE_IGNORED, 0);
        add_row(CMD_FREE,  0,      801,    1'b1, ST_FREE_IGNORED, 0);
        add_row(CMD_FREE,  0,      102400, 1'b1, ST_FREE_IGNORED, 0);
        add_row(CMD_ALLOC, 1,      0,      1'b0, ST_ALLOCATED,    0);
        add_row(CMD_FREE,  0,      1600,   1'b0, ST_ALLOCATED,    0);
        add_row(CMD_FREE,  0,      800,    1'b0, ST_ALLOCATED,    0);
        add_row(CMD_FREE,  0,      0,      1'b0, ST_ALLOCATED,    0);
        add_row(CMD_ALLOC, 102400, 0,      1'b1, ST_ALLOCATED,    0);
        add_row(CMD_ALLOC, 1,      0,      1'b1, ST_NO_SPACE,     0);
        add_row(CMD_FREE,  0,      101600, 1'b1, ST_FREE_IGNORED, 0);
        add_row(CMD_FREE,  0,      0,      1'b1, ST_FREED,        0);
        add_row(CMD_ALLOC, 101601, 0,      1'b0, ST_ALLOCATED,    0);
        add_row(CMD_ALLOC, 800,    0,      1'b0, ST_ALLOCATED,    0);
        add_row(CMD_ALLOC, 1,      0,      1'b1, ST_NO_SPACE,     0);
        add_row(CMD_FREE,  131071, 101600, 1'b0, ST_ALLOCATED,    0);
        add_row(CMD_ALLOC, 1,      131071, 1'b0, ST_ALLOCATED,    0);
        add_row(CMD_FREE,  0,      0,      1'b0, ST_ALLOCATED,    0);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // receiver backs off for a while so the block fills and stalls its input
            if (n == 300)
                hold_off_req = 1'b1;
            if (n == 800)
            begin
                in_valid = 1'b0;
                while (awaited_replies.size() != 0)
                    @(negedge clk);
            end
            tx_gaps_on = !(n >= 500 && n < 700);
            rx_gaps_on = !(n >= 1100 && n < 1300);
            make_random_row(row);
            send_request(row);
        end
        in_valid = 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
